// ===== hw/rtl/ims_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ims_pkg
// Types and constants shared by the idle misfire criterion unit.
// ----------------------------------------------------------------------------
package ims_pkg;

  localparam int unsigned DelayW    = 32;
  localparam int unsigned AvgW      = 17;
  localparam int unsigned DenW      = 19;
  localparam int unsigned ExcessW   = 21;
  localparam int unsigned DividendW = 32;
  localparam int unsigned QuotW     = 16;
  localparam int unsigned CritW     = 15;
  localparam int unsigned SelW      = 2;
  localparam int unsigned LineDepth = 4;

  localparam logic [DelayW-1:0] DelayLimit = 32'd199998;
  localparam logic [AvgW-1:0]   AvgCap     = 17'd99999;
  localparam logic [CritW-1:0]  CritCap    = 15'd32767;

  // delay selector codes
  localparam logic [SelW-1:0] SelCurrent = 2'd0;
  localparam logic [SelW-1:0] SelOneBack = 2'd1;
  localparam logic [SelW-1:0] SelTwoBack = 2'd2;

  typedef enum logic [2:0] {
    ImsIdle,
    ImsPrep,
    ImsDivA,
    ImsDivB,
    ImsFinish
  } ims_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } ims_div_stat_t;

endpackage

// ===== hw/rtl/ims_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ims_if
// Valid/ready channels of the idle misfire criterion unit.
// ----------------------------------------------------------------------------
interface ims_in_if;
  logic                         valid;
  logic                         ready;
  logic                         idle_active;
  logic [ims_pkg::DelayW-1:0]   exp_window_delay;
  logic [ims_pkg::DelayW-1:0]   bdc_window_delay;

  modport source (output valid, idle_active, exp_window_delay, bdc_window_delay,
                  input ready);
  modport sink   (input valid, idle_active, exp_window_delay, bdc_window_delay,
                  output ready);
endinterface

interface ims_out_if;
  logic                        valid;
  logic                        ready;
  logic                        updated;
  logic [ims_pkg::CritW-1:0]   algo_output;
  logic [ims_pkg::CritW-1:0]   criterion_next;
  logic [ims_pkg::CritW-1:0]   criterion_now;
  logic [ims_pkg::CritW-1:0]   criterion_prev;
  logic [ims_pkg::CritW-1:0]   criterion_prev_prev;

  modport source (output valid, updated, algo_output, criterion_next, criterion_now,
                  criterion_prev, criterion_prev_prev, input ready);
  modport sink   (input valid, updated, algo_output, criterion_next, criterion_now,
                  criterion_prev, criterion_prev_prev, output ready);
endinterface

interface ims_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ims_pkg::SelW-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/ims_div_serial.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ims_div_serial
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ims_div_serial (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [ims_pkg::DividendW-1:0]    dividend_i,
  input  logic [ims_pkg::DenW-1:0]         divisor_i,
  output ims_pkg::ims_div_stat_t           stat_o,
  output logic [ims_pkg::QuotW-1:0]        quotient_o
);

  localparam int unsigned CntW    = $clog2(ims_pkg::DividendW);
  localparam logic [CntW-1:0] LastStep = CntW'(ims_pkg::DividendW - 1);

  logic [ims_pkg::DividendW-1:0] dvd_q, dvd_d;
  logic [ims_pkg::DenW-1:0]      div_q, div_d;
  logic [ims_pkg::DenW-1:0]      rem_q, rem_d;
  logic [ims_pkg::QuotW-1:0]     quo_q, quo_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [ims_pkg::DenW:0]        trial;
  logic [ims_pkg::DenW:0]        diff;
  logic                          fits;

  // partial remainder with next dividend bit, and trial subtract
  assign trial = {rem_q, dvd_q[ims_pkg::DividendW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = (trial >= {1'b0, div_q});

  always_comb begin
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[ims_pkg::DividendW-2:0], 1'b0};
      rem_d = fits ? diff[ims_pkg::DenW-1:0] : trial[ims_pkg::DenW-1:0];
      quo_d = {quo_q[ims_pkg::QuotW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

// ===== hw/rtl/idle_misfire_criterion_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_misfire_criterion_unit
// Idle misfire criterion: per combustion event, averaged window delay, scaled
// rise ratio and a four-deep criterion line.
// ----------------------------------------------------------------------------
// One transaction on in_i is one combustion event and gives exactly one
// transaction on out_o. A held event (idle_active 0), or one with a zero
// denominator or no positive rise, skips the divider and goes from Prep
// straight to Finish. Otherwise the ratio comes from a bit-serial restoring
// divider of 32 steps, run once for an even delay sum and twice for an odd
// one. The divider sets the rate; a stalled out_o adds its stall. One
// item is in work at a time; the result sits in an output register, so the
// next event is taken while it waits. sync_delay_select must be written on
// cfg_i only while the unit is idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module idle_misfire_criterion_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  ims_in_if.sink     in_i,
  ims_cfg_if.sink    cfg_i,
  ims_out_if.source  out_o
);

  // --------------------------------------------------------------------------
  // State and datapath registers
  // --------------------------------------------------------------------------
  ims_pkg::ims_state_e state_q, state_d;

  logic [ims_pkg::SelW-1:0]  sel_q;
  logic [ims_pkg::AvgW-1:0]  avg_last_q, avg_older_q;
  logic [ims_pkg::QuotW-1:0] ratio_last_q, ratio_older_q;
  logic [ims_pkg::CritW-1:0] line_q [ims_pkg::LineDepth];

  // current transaction
  logic                         active_q;
  logic [ims_pkg::AvgW-1:0]     avg_q;
  logic                         rem_q;
  logic [ims_pkg::QuotW-1:0]    quo_a_q;
  logic [ims_pkg::QuotW-1:0]    ratio_q, ratio_d;

  // output register
  logic                         out_valid_q;
  logic                         out_updated_q;
  logic [ims_pkg::CritW-1:0]    out_algo_q;
  logic [ims_pkg::CritW-1:0]    out_line_q [ims_pkg::LineDepth];

  // --------------------------------------------------------------------------
  // Average of the two delays, taken at acceptance
  // --------------------------------------------------------------------------
  logic [ims_pkg::DelayW:0]   delay_sum;
  logic                       too_long;
  logic [ims_pkg::DelayW-1:0] half_sum;
  logic [ims_pkg::AvgW-1:0]   avg_in;
  logic                       rem_in;

  assign delay_sum = {1'b0, in_i.exp_window_delay} + {1'b0, in_i.bdc_window_delay};
  assign too_long  = (in_i.exp_window_delay > ims_pkg::DelayLimit) ||
                     (in_i.bdc_window_delay > ims_pkg::DelayLimit);
  assign half_sum  = delay_sum[ims_pkg::DelayW:1];

  always_comb begin
    if (too_long) begin
      avg_in = ims_pkg::AvgCap;
      rem_in = 1'b0;
    end else begin
      // remainder kept even when the average is capped
      avg_in = (half_sum > {15'd0, ims_pkg::AvgCap}) ? ims_pkg::AvgCap
                                                     : half_sum[ims_pkg::AvgW-1:0];
      rem_in = delay_sum[0];
    end
  end

  // --------------------------------------------------------------------------
  // Numerator and denominator, stable from acceptance until the line steps
  //   num = avg*24576 + rem*12288 - last*24576 = (6*avg + 3*rem - 6*last) << 12
  // --------------------------------------------------------------------------
  logic [ims_pkg::AvgW+2:0]          six_avg, six_last;
  logic signed [ims_pkg::ExcessW-1:0] excess;
  logic                              num_pos;
  logic [ims_pkg::DividendW-1:0]     num_calc;
  logic [ims_pkg::DenW-1:0]          den_calc;

  assign six_avg  = {1'b0, avg_q, 2'b00} + {2'b00, avg_q, 1'b0};
  assign six_last = {1'b0, avg_last_q, 2'b00} + {2'b00, avg_last_q, 1'b0};
  assign excess   = $signed({1'b0, six_avg}) + $signed({19'd0, rem_q, rem_q})
                  - $signed({1'b0, six_last});
  assign num_pos  = !excess[ims_pkg::ExcessW-1] && (excess != '0);
  assign num_calc = num_pos ? {excess[ims_pkg::ExcessW-2:0], 12'd0} : '0;
  assign den_calc = {2'b00, avg_last_q} + {2'b00, avg_older_q} + {2'b00, avg_q};

  // --------------------------------------------------------------------------
  // Serial divider, shared by both quotients
  // --------------------------------------------------------------------------
  logic                          div_start;
  logic [ims_pkg::DenW-1:0]      div_divisor;
  ims_pkg::ims_div_stat_t        div_stat;
  logic [ims_pkg::QuotW-1:0]     div_quot;

  ims_div_serial u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_calc),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (div_quot)
  );

  // --------------------------------------------------------------------------
  // Control: next state
  // --------------------------------------------------------------------------
  logic in_fire;
  logic out_free;
  logic prep_zero;

  assign in_fire   = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign prep_zero = (den_calc == '0) || !num_pos;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ims_pkg::ImsIdle:   if (in_fire) state_d = ims_pkg::ImsPrep;
      ims_pkg::ImsPrep: begin
        if (!active_q || prep_zero) state_d = ims_pkg::ImsFinish;
        else                        state_d = ims_pkg::ImsDivA;
      end
      ims_pkg::ImsDivA: begin
        if (div_stat.done) state_d = rem_q ? ims_pkg::ImsDivB : ims_pkg::ImsFinish;
      end
      ims_pkg::ImsDivB:   if (div_stat.done) state_d = ims_pkg::ImsFinish;
      ims_pkg::ImsFinish: if (out_free) state_d = ims_pkg::ImsIdle;
      default:            state_d = ims_pkg::ImsIdle;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control: outputs
  // --------------------------------------------------------------------------
  logic out_load;

  always_comb begin
    in_i.ready  = 1'b0;
    div_start   = 1'b0;
    div_divisor = den_calc;
    out_load    = 1'b0;
    unique case (state_q)
      ims_pkg::ImsIdle:   in_i.ready = 1'b1;
      ims_pkg::ImsPrep:   div_start  = active_q && !prep_zero;
      ims_pkg::ImsDivA: begin
        // second pass over den + 1 for an odd delay sum
        div_start   = div_stat.done && rem_q;
        div_divisor = den_calc + 1'b1;
      end
      ims_pkg::ImsDivB:   div_start = 1'b0;
      ims_pkg::ImsFinish: out_load  = out_free;
      default:            out_load  = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Ratio: a for even sums, b + (a - b)/2 for odd sums
  // --------------------------------------------------------------------------
  logic [ims_pkg::QuotW-1:0] quo_gap;

  assign quo_gap = quo_a_q - div_quot;

  always_comb begin
    ratio_d = ratio_q;
    if (state_q == ims_pkg::ImsPrep) begin
      ratio_d = '0;
    end else if (state_q == ims_pkg::ImsDivA && div_stat.done) begin
      ratio_d = div_quot;
    end else if (state_q == ims_pkg::ImsDivB && div_stat.done) begin
      ratio_d = div_quot + {1'b0, quo_gap[ims_pkg::QuotW-1:1]};
    end
  end

  // --------------------------------------------------------------------------
  // Delayed ratio pick and cap
  // --------------------------------------------------------------------------
  logic [ims_pkg::QuotW-1:0] pick_raw;
  logic [ims_pkg::CritW-1:0] pick;

  always_comb begin
    case (sel_q)
      ims_pkg::SelOneBack: pick_raw = ratio_last_q;
      ims_pkg::SelTwoBack: pick_raw = ratio_older_q;
      default:             pick_raw = ratio_q;
    endcase
    pick = (pick_raw > {1'b0, ims_pkg::CritCap}) ? ims_pkg::CritCap
                                                 : pick_raw[ims_pkg::CritW-1:0];
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ims_pkg::ImsIdle;
      sel_q         <= ims_pkg::SelCurrent;
      avg_last_q    <= '0;
      avg_older_q   <= '0;
      ratio_last_q  <= '0;
      ratio_older_q <= '0;
      for (int i = 0; i < ims_pkg::LineDepth; i++) line_q[i] <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) sel_q <= cfg_i.data;
      if (out_load && active_q) begin
        line_q[0]     <= pick;
        for (int i = 1; i < ims_pkg::LineDepth; i++) line_q[i] <= line_q[i-1];
        ratio_older_q <= ratio_last_q;
        ratio_last_q  <= ratio_q;
        avg_older_q   <= avg_last_q;
        avg_last_q    <= avg_q;
      end
      if (out_load)          out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      active_q <= in_i.idle_active;
      avg_q    <= avg_in;
      rem_q    <= rem_in;
    end
    if (state_q == ims_pkg::ImsDivA && div_stat.done) quo_a_q <= div_quot;
    ratio_q <= ratio_d;
    if (out_load) begin
      out_updated_q <= active_q;
      if (active_q) begin
        out_algo_q    <= line_q[0];
        out_line_q[0] <= pick;
        for (int i = 1; i < ims_pkg::LineDepth; i++) out_line_q[i] <= line_q[i-1];
      end else begin
        out_algo_q <= '0;
        for (int i = 0; i < ims_pkg::LineDepth; i++) out_line_q[i] <= line_q[i];
      end
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.updated             = out_updated_q;
  assign out_o.algo_output         = out_algo_q;
  assign out_o.criterion_next      = out_line_q[0];
  assign out_o.criterion_now       = out_line_q[1];
  assign out_o.criterion_prev      = out_line_q[2];
  assign out_o.criterion_prev_prev = out_line_q[3];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // divider never restarted mid-run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // divider completes only while a quotient is awaited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ims_pkg::ImsDivA || state_q == ims_pkg::ImsDivB))
    else $error("divider done outside a division state");

  // a stepped transaction shows the old newest criterion one place down
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && active_q) |=> (out_o.criterion_now == $past(line_q[0]) &&
                                out_o.algo_output == $past(line_q[0])))
    else $error("criterion line shift mismatch");

  // a held transaction delivers zero and leaves the line alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !active_q) |=> (out_o.algo_output == '0 && $stable(line_q[0])))
    else $error("held transaction altered the criterion");
`endif

endmodule
